[rtl/core/apv_pkg.sv]
// Shared types, constants and helpers for the APV frame stream decoder.
// No dependencies; the front, queue, back, top level and testbench refer to this package.
package apv_pkg;

  // Word patterns of the readout stream
  localparam logic [23:0] HEADER_TAG = 24'h414443;
  localparam logic [31:0] TRAILER    = 32'hfafafafa;

  // Configuration reset values
  localparam logic [15:0] LOW_THRESHOLD_RESET = 16'd1500;
  localparam logic [9:0]  SCAN_LENGTH_RESET   = 10'd100;

  // Geometry of the active map: 16 bits per board, 4 boards per 64-bit register
  localparam int NUM_BOARDS         = 8;
  localparam int CHANNELS_PER_BOARD = 16;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MAP_LOW       = 2'd0,
    REG_MAP_HIGH      = 2'd1,
    REG_LOW_THRESHOLD = 2'd2,
    REG_SCAN_LENGTH   = 2'd3
  } apv_reg_t;

  // Parse state of the front
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_BOARD   = 2'd1,
    MODE_SAMPLES = 2'd2
  } apv_mode_t;

  typedef struct packed {
    logic [63:0] map_low;
    logic [63:0] map_high;
    logic [15:0] low_threshold;
    logic [9:0]  scan_length;
  } apv_cfg_t;

  // Scan state of the low-run search in inactive channels
  typedef struct packed {
    logic [9:0] scanned;
    logic [1:0] low_run;
    logic       warn;
  } apv_scan_t;

  // One queued request: an optional sample item followed by an optional end item
  typedef struct packed {
    logic        has_sample;
    logic        has_end;
    logic [7:0]  board_id;
    logic [7:0]  channel;
    logic [15:0] sample_first;
    logic [15:0] sample_second;
    logic        end_active;
    logic        end_warning;
  } apv_cmd_t;

  // Push side of the queue
  typedef struct packed {
    logic     push;
    apv_cmd_t cmd;
  } apv_push_t;

  // Head side of the queue
  typedef struct packed {
    logic     empty;
    logic     full;
    apv_cmd_t head;
  } apv_head_t;

endpackage

[rtl/core/apv_stream_if.sv]
// Valid/ready stream interfaces of the APV frame stream decoder.
// Depends on nothing; the raw word channel and the decoded result channel.
interface apv_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface apv_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  board_id;
  logic [7:0]  channel;
  logic [15:0] sample_first;
  logic [15:0] sample_second;
  logic        channel_active;
  logic        inactive_warning;
  logic        last;

  modport source (output valid, output kind, output board_id, output channel,
                  output sample_first, output sample_second, output channel_active,
                  output inactive_warning, output last, input ready);
  modport sink   (input valid, input kind, input board_id, input channel,
                  input sample_first, input sample_second, input channel_active,
                  input inactive_warning, input last, output ready);
endinterface

[rtl/core/apv_front.sv]
// Front of the decoder: accepts raw words, tracks the block parse state and
// pushes one request per word that causes results. Uses apv_pkg, apv_word_if.
module apv_front (
  input  logic               clk,
  input  logic               rst,
  apv_word_if.sink           raw,
  input  apv_pkg::apv_cfg_t  cfg,
  input  logic               queue_full,
  output apv_pkg::apv_push_t req
);

  apv_pkg::apv_mode_t mode, mode_next;
  logic [7:0]         board, board_next;
  logic [7:0]         channel, channel_next;
  logic [31:0]        held_word, held_word_next;
  logic               held_valid, held_valid_next;
  apv_pkg::apv_scan_t scan, scan_next;

  logic               accept;
  logic               is_header;
  logic               is_trailer;
  logic [15:0]        held_first;
  logic [15:0]        held_second;
  apv_pkg::apv_scan_t scan_one;
  apv_pkg::apv_scan_t scan_two;
  logic               active_cur;
  logic               active_word;

  // Channel lookup in the active map
  function automatic logic chan_active(input logic [7:0] b, input logic [7:0] c,
                                       input apv_pkg::apv_cfg_t m);
    logic [127:0] map;
    logic [6:0]   idx;
    map = {m.map_high, m.map_low};
    idx = {b[2:0], c[3:0]};
    return (b < 8'(apv_pkg::NUM_BOARDS)) && (c < 8'(apv_pkg::CHANNELS_PER_BOARD)) &&
           map[idx];
  endfunction

  // One sample through the low-run search
  function automatic apv_pkg::apv_scan_t scan_step(input apv_pkg::apv_scan_t st,
                                                   input logic [15:0] s,
                                                   input apv_pkg::apv_cfg_t m);
    apv_pkg::apv_scan_t r;
    r = st;
    if (st.scanned < m.scan_length) begin
      r.scanned = st.scanned + 10'd1;
      if (s < m.low_threshold) begin
        if (st.low_run != 2'd3) begin
          r.low_run = st.low_run + 2'd1;
        end
        if (r.low_run == 2'd3) begin
          r.warn = 1'b1;
        end
      end else begin
        r.low_run = 2'd0;
      end
    end
    return r;
  endfunction

  assign raw.ready   = !queue_full;
  assign accept      = raw.valid && raw.ready;
  assign is_header   = raw.word[31:8] == apv_pkg::HEADER_TAG;
  assign is_trailer  = raw.word == apv_pkg::TRAILER;
  assign held_first  = {held_word[23:16], held_word[31:24]};
  assign held_second = {held_word[7:0], held_word[15:8]};
  assign scan_one    = scan_step(scan, held_first, cfg);
  assign scan_two    = scan_step(scan_one, held_second, cfg);
  assign active_cur  = chan_active(board, channel, cfg);
  assign active_word = chan_active(raw.word[23:16], channel, cfg);

  // Next parse state and the request for this word
  always_comb begin
    mode_next       = mode;
    board_next      = board;
    channel_next    = channel;
    held_word_next  = held_word;
    held_valid_next = held_valid;
    scan_next       = scan;
    req.push        = 1'b0;
    req.cmd         = '0;
    req.cmd.board_id      = board;
    req.cmd.channel       = channel;
    req.cmd.sample_first  = held_first;
    req.cmd.sample_second = held_second;
    req.cmd.end_active    = active_cur;
    req.cmd.end_warning   = !active_cur && scan.warn;

    if (accept) begin
      unique case (mode)
        apv_pkg::MODE_BOARD: begin
          board_next             = raw.word[23:16];
          req.cmd.board_id       = raw.word[23:16];
          req.cmd.end_active     = active_word;
          req.cmd.end_warning    = !active_word && scan.warn;
          if (is_header || is_trailer) begin
            req.cmd.has_end = 1'b1;
            mode_next       = is_header ? apv_pkg::MODE_BOARD : apv_pkg::MODE_IDLE;
          end else begin
            mode_next = apv_pkg::MODE_SAMPLES;
          end
        end
        apv_pkg::MODE_SAMPLES: begin
          if (is_header) begin
            req.cmd.has_end = 1'b1;
            mode_next       = apv_pkg::MODE_BOARD;
          end else begin
            // commit the held word
            if (held_valid) begin
              scan_next          = scan_two;
              held_valid_next    = 1'b0;
              req.cmd.has_sample = active_cur;
              req.cmd.end_warning = !active_cur && scan_two.warn;
            end
            if (is_trailer) begin
              req.cmd.has_end = 1'b1;
              mode_next       = apv_pkg::MODE_IDLE;
            end else begin
              held_word_next  = raw.word;
              held_valid_next = 1'b1;
            end
          end
        end
        default: begin
          mode_next = is_header ? apv_pkg::MODE_BOARD : apv_pkg::MODE_IDLE;
        end
      endcase

      // open a new block on any header
      if (is_header) begin
        channel_next    = raw.word[7:0];
        board_next      = 8'd0;
        held_word_next  = 32'd0;
        held_valid_next = 1'b0;
        scan_next       = '0;
      end
      req.push = req.cmd.has_sample || req.cmd.has_end;
    end
  end

  // Hold the parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= apv_pkg::MODE_IDLE;
      board      <= 8'd0;
      channel    <= 8'd0;
      held_valid <= 1'b0;
      scan       <= '0;
    end else begin
      mode       <= mode_next;
      board      <= board_next;
      channel    <= channel_next;
      held_valid <= held_valid_next;
      scan       <= scan_next;
    end
  end

  always_ff @(posedge clk) begin
    held_word <= held_word_next;
  end

endmodule

[rtl/core/apv_queue.sv]
// Short request queue between the front and the back of the decoder.
// Uses apv_pkg for the request type and the depth.
module apv_queue (
  input  logic               clk,
  input  logic               rst,
  input  apv_pkg::apv_push_t wr,
  input  logic               pop,
  output apv_pkg::apv_head_t rd
);

  localparam int PtrW = $clog2(apv_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(apv_pkg::QUEUE_DEPTH + 1);

  apv_pkg::apv_cmd_t entries [apv_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;

  assign rd.empty = count == '0;
  assign rd.full  = count == CntW'(apv_pkg::QUEUE_DEPTH);
  assign rd.head  = entries[rd_ptr];

  // Store pushed requests
  always_ff @(posedge clk) begin
    if (wr.push) begin
      entries[wr_ptr] <= wr.cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.push) begin
        wr_ptr <= (wr_ptr == PtrW'(apv_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(apv_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({wr.push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/core/apv_back.sv]
// Back of the decoder: expands each queued request into its result items and
// holds them in an output register. Uses apv_pkg, apv_result_if.
module apv_back (
  input  logic               clk,
  input  logic               rst,
  input  apv_pkg::apv_head_t rd,
  output logic               pop,
  apv_result_if.source       decoded
);

  logic out_valid;
  logic phase, phase_next;
  logic load;
  logic take_sample;

  // Pick the next item from the queue head
  always_comb begin
    load        = !rd.empty && (!out_valid || decoded.ready);
    take_sample = !phase && rd.head.has_sample;
    pop         = load && (!take_sample || !rd.head.has_end);
    phase_next  = take_sample && rd.head.has_end;
  end

  // Hold the item until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      phase     <= phase_next;
    end else if (decoded.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      decoded.board_id <= rd.head.board_id;
      decoded.channel  <= rd.head.channel;
      if (take_sample) begin
        decoded.kind             <= 1'b0;
        decoded.sample_first     <= rd.head.sample_first;
        decoded.sample_second    <= rd.head.sample_second;
        decoded.channel_active   <= 1'b1;
        decoded.inactive_warning <= 1'b0;
        decoded.last             <= !rd.head.has_end;
      end else begin
        decoded.kind             <= 1'b1;
        decoded.sample_first     <= 16'd0;
        decoded.sample_second    <= 16'd0;
        decoded.channel_active   <= rd.head.end_active;
        decoded.inactive_warning <= rd.head.end_warning;
        decoded.last             <= 1'b1;
      end
    end
  end

  assign decoded.valid = out_valid;

endmodule

[rtl/core/apv_frame_stream_decoder.sv]
// Top level of the APV frame stream decoder: configuration registers, front,
// request queue and back. Uses apv_pkg, apv_stream_if, apv_front/queue/back.
//
//   channel   dir   handshake        payload
//   raw       in    valid/ready      word[31:0]
//   decoded   out   valid/ready      kind, board_id, channel, samples, flags, last
//   config    in    write_enable     write_index[1:0], write_data[63:0]
//
// A raw word is taken every cycle while the 4-entry request queue has room.
// A result item passes through the request queue and the output register; a word
// causing two items gives them one item per cycle while the sink is ready.
// Synchronous reset clears parse state, queue and output; config returns to defaults.
// A stalled sink fills the queue, then drops raw.ready until the back drains it.
module apv_frame_stream_decoder (
  input  logic         clk,
  input  logic         rst,
  apv_word_if.sink     raw,
  apv_result_if.source decoded,
  input  logic         write_enable,
  input  logic [1:0]   write_index,
  input  logic [63:0]  write_data
);

  apv_pkg::apv_cfg_t  cfg;
  apv_pkg::apv_push_t req;
  apv_pkg::apv_head_t rd;
  logic               pop;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_low       <= 64'd0;
      cfg.map_high      <= 64'd0;
      cfg.low_threshold <= apv_pkg::LOW_THRESHOLD_RESET;
      cfg.scan_length   <= apv_pkg::SCAN_LENGTH_RESET;
    end else if (write_enable) begin
      unique case (apv_pkg::apv_reg_t'(write_index))
        apv_pkg::REG_MAP_LOW:       cfg.map_low       <= write_data;
        apv_pkg::REG_MAP_HIGH:      cfg.map_high      <= write_data;
        apv_pkg::REG_LOW_THRESHOLD: cfg.low_threshold <= write_data[15:0];
        apv_pkg::REG_SCAN_LENGTH:   cfg.scan_length   <= write_data[9:0];
        default:                    cfg               <= cfg;
      endcase
    end
  end

  apv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .raw        (raw),
    .cfg        (cfg),
    .queue_full (rd.full),
    .req        (req)
  );

  apv_queue u_queue (
    .clk (clk),
    .rst (rst),
    .wr  (req),
    .pop (pop),
    .rd  (rd)
  );

  apv_back u_back (
    .clk     (clk),
    .rst     (rst),
    .rd      (rd),
    .pop     (pop),
    .decoded (decoded)
  );

endmodule

[rtl/core/apv_checker.sv]
// Port-level checks of the APV frame stream decoder, bound to the top level.
// Depends on apv_frame_stream_decoder and its port names only.
module apv_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        kind,
  input logic [7:0]  board_id,
  input logic [7:0]  channel,
  input logic [15:0] sample_first,
  input logic [15:0] sample_second,
  input logic        channel_active,
  input logic        inactive_warning,
  input logic        last
);

  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(board_id) &&
    $stable(channel) && $stable(sample_first) && $stable(sample_second) &&
    $stable(channel_active) && $stable(inactive_warning) && $stable(last))
    else $error("stalled result changed");

  // End items carry no samples and close the word's results
  a_end_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> sample_first == 16'd0 && sample_second == 16'd0 && last)
    else $error("malformed end item");

  // Sample items come only from active channels
  a_sample_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> channel_active && !inactive_warning)
    else $error("sample item from inactive channel");

  // A sample item that is not last is followed by its end item
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !kind && !last |=> out_valid && kind &&
    board_id == $past(board_id) && channel == $past(channel))
    else $error("end item missing after sample item");

endmodule

bind apv_frame_stream_decoder apv_checker u_apv_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (decoded.valid),
  .out_ready        (decoded.ready),
  .kind             (decoded.kind),
  .board_id         (decoded.board_id),
  .channel          (decoded.channel),
  .sample_first     (decoded.sample_first),
  .sample_second    (decoded.sample_second),
  .channel_active   (decoded.channel_active),
  .inactive_warning (decoded.inactive_warning),
  .last             (decoded.last)
);

[verif/apv_frame_stream_decoder_tb.sv]
// Self-checking testbench for apv_frame_stream_decoder: drives raw readout words and
// register writes, predicts every decoded item and checks it in order.
// Depends on apv_pkg, apv_stream_if.sv and the decoder RTL.
module apv_frame_stream_decoder_tb;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int PHASE_WORDS   = 195;
  localparam int NUM_PHASES    = 8;

  // One decoded item as seen on the result channel
  typedef struct {
    logic        kind;
    logic [7:0]  board_id;
    logic [7:0]  channel;
    logic [15:0] sample_first;
    logic [15:0] sample_second;
    logic        channel_active;
    logic        inactive_warning;
    logic        last;
  } decoded_item_t;

  // Predict decoded items from accepted words and compare against the result channel
  class decode_scoreboard;
    logic [63:0]         map_low, map_high;
    logic [15:0]         threshold;
    logic [9:0]          scan_len;
    apv_pkg::apv_mode_t  mode;
    logic [7:0]          board, channel;
    logic [31:0]         held;
    bit                  held_ok;
    logic [9:0]          scanned;
    logic [1:0]          low_run;
    bit                  warn_seen;
    decoded_item_t       pending_items[$];
    int unsigned         errors, words_seen, samples_checked, ends_checked, warnings_checked;

    function new();
      map_low   = '0;
      map_high  = '0;
      threshold = apv_pkg::LOW_THRESHOLD_RESET;
      scan_len  = apv_pkg::SCAN_LENGTH_RESET;
      mode      = apv_pkg::MODE_IDLE;
      open_block(8'h00);
    endfunction

    function void set_register(apv_pkg::apv_reg_t idx, logic [63:0] data);
      case (idx)
        apv_pkg::REG_MAP_LOW:       map_low = data;
        apv_pkg::REG_MAP_HIGH:      map_high = data;
        apv_pkg::REG_LOW_THRESHOLD: threshold = data[15:0];
        apv_pkg::REG_SCAN_LENGTH:   scan_len = data[9:0];
        default: ;
      endcase
    endfunction

    function bit channel_on();
      logic [5:0] pos;
      pos = {board[1:0], channel[3:0]};
      if (board >= 8'(apv_pkg::NUM_BOARDS) || channel >= 8'(apv_pkg::CHANNELS_PER_BOARD))
        return 1'b0;
      return board[2] ? map_high[pos] : map_low[pos];
    endfunction

    // Count low runs only within the leading scan window
    function void scan(logic [15:0] s);
      if (scanned >= scan_len) return;
      scanned++;
      if (s < threshold) begin
        if (low_run < 2'd3) low_run++;
        if (low_run == 2'd3) warn_seen = 1'b1;
      end else begin
        low_run = '0;
      end
    endfunction

    function void emit(logic kind, logic [15:0] s1, logic [15:0] s2, logic act, logic warn);
      decoded_item_t it;
      it.kind             = kind;
      it.board_id         = board;
      it.channel          = channel;
      it.sample_first     = s1;
      it.sample_second    = s2;
      it.channel_active   = act;
      it.inactive_warning = warn;
      it.last             = 1'b0;
      pending_items.insert(pending_items.size(), it);
    endfunction

    // Split the held word into byte-swapped samples
    function void commit();
      logic [15:0] s1, s2;
      if (!held_ok) return;
      s1 = {held[23:16], held[31:24]};
      s2 = {held[7:0], held[15:8]};
      held_ok = 1'b0;
      scan(s1);
      scan(s2);
      if (channel_on()) emit(1'b0, s1, s2, 1'b1, 1'b0);
    endfunction

    function void finish_block();
      bit act;
      act = channel_on();
      emit(1'b1, '0, '0, act, !act && warn_seen);
    endfunction

    function void open_block(logic [7:0] ch);
      channel   = ch;
      board     = '0;
      held      = '0;
      held_ok   = 1'b0;
      scanned   = '0;
      low_run   = '0;
      warn_seen = 1'b0;
    endfunction

    function void note_word(logic [31:0] w);
      int  count_prior;
      bit  is_hdr, is_trl;
      count_prior = pending_items.size();
      is_hdr = (w[31:8] == apv_pkg::HEADER_TAG);
      is_trl = (w == apv_pkg::TRAILER);
      words_seen++;
      case (mode)
        apv_pkg::MODE_BOARD: begin
          board = w[23:16];
          if (is_hdr) begin
            finish_block();
            open_block(w[7:0]);
            mode = apv_pkg::MODE_BOARD;
          end else if (is_trl) begin
            finish_block();
            mode = apv_pkg::MODE_IDLE;
          end else begin
            mode = apv_pkg::MODE_SAMPLES;
          end
        end
        apv_pkg::MODE_SAMPLES: begin
          if (is_hdr) begin
            // drop the held word
            held_ok = 1'b0;
            finish_block();
            open_block(w[7:0]);
            mode = apv_pkg::MODE_BOARD;
          end else if (is_trl) begin
            commit();
            finish_block();
            mode = apv_pkg::MODE_IDLE;
          end else begin
            commit();
            held    = w;
            held_ok = 1'b1;
          end
        end
        default: begin
          if (is_hdr) begin
            open_block(w[7:0]);
            mode = apv_pkg::MODE_BOARD;
          end else begin
            mode = apv_pkg::MODE_IDLE;
          end
        end
      endcase
      if (pending_items.size() > count_prior)
        pending_items[pending_items.size() - 1].last = 1'b1;
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0h, got %0h", name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(decoded_item_t got);
      decoded_item_t want;
      if (pending_items.size() == 0) begin
        $error("decoded item with no request pending: kind %0h channel %0h",
               got.kind, got.channel);
        errors++;
        return;
      end
      want = pending_items.pop_front();
      compare_field("kind", 16'(want.kind), 16'(got.kind));
      compare_field("board_id", 16'(want.board_id), 16'(got.board_id));
      compare_field("channel", 16'(want.channel), 16'(got.channel));
      compare_field("sample_first", want.sample_first, got.sample_first);
      compare_field("sample_second", want.sample_second, got.sample_second);
      compare_field("channel_active", 16'(want.channel_active), 16'(got.channel_active));
      compare_field("inactive_warning", 16'(want.inactive_warning),
                    16'(got.inactive_warning));
      compare_field("last", 16'(want.last), 16'(got.last));
      if (want.kind) ends_checked++;
      else samples_checked++;
      if (want.inactive_warning) warnings_checked++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        write_enable;
  logic [1:0]  write_index;
  logic [63:0] write_data;

  apv_word_if   raw ();
  apv_result_if decoded ();

  apv_frame_stream_decoder uut (
    .clk          (clk),
    .rst          (rst),
    .raw          (raw),
    .decoded      (decoded),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data)
  );

  decode_scoreboard decode_sb = new();

  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned holds_asked;
  int unsigned holds_served;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned settings_used;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("apv_frame_stream_decoder regression: fail");
      $finish;
    end
  end

  // Receive side: check each accepted item, then pick ready for the next edge
  always @(posedge clk) begin : receive_side
    decoded_item_t got;
    if (decoded.valid && decoded.ready) begin
      got.kind             = decoded.kind;
      got.board_id         = decoded.board_id;
      got.channel          = decoded.channel;
      got.sample_first     = decoded.sample_first;
      got.sample_second    = decoded.sample_second;
      got.channel_active   = decoded.channel_active;
      got.inactive_warning = decoded.inactive_warning;
      got.last             = decoded.last;
      decode_sb.check_result(got);
    end
    if (rst) begin
      decoded.ready <= 1'b0;
    end else if (hold_left > 0) begin
      decoded.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      // hold off long enough for the request queue to fill
      holds_served  <= holds_served + 1;
      hold_left     <= LONG_HOLD;
      decoded.ready <= 1'b0;
    end else begin
      decoded.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Offer one word, idling at random first, and hold it until accepted
  task automatic send_word(input logic [31:0] w);
    while ($urandom_range(0, 99) < gap_pct) begin
      raw.valid <= 1'b0;
      @(posedge clk);
    end
    raw.valid <= 1'b1;
    raw.word  <= w;
    @(posedge clk);
    while (!raw.ready) @(posedge clk);
    decode_sb.note_word(w);
  endtask

  // Stop offering and let every expected item drain
  task automatic wait_idle();
    raw.valid <= 1'b0;
    while (decode_sb.pending_items.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(apv_pkg::apv_reg_t idx, logic [63:0] data);
    write_enable <= 1'b1;
    write_index  <= idx;
    write_data   <= data;
    @(posedge clk);
    decode_sb.set_register(idx, data);
  endtask

  task automatic write_config(logic [63:0] map_lo, logic [63:0] map_hi,
                              logic [15:0] thr, logic [9:0] scan);
    put_reg(apv_pkg::REG_MAP_LOW, map_lo);
    put_reg(apv_pkg::REG_MAP_HIGH, map_hi);
    put_reg(apv_pkg::REG_LOW_THRESHOLD, {48'b0, thr});
    put_reg(apv_pkg::REG_SCAN_LENGTH, {54'b0, scan});
    write_enable <= 1'b0;
    settings_used++;
  endtask

  // Bias samples toward the threshold so low runs occur
  function automatic logic [15:0] pick_sample();
    logic [15:0] thr;
    thr = decode_sb.threshold;
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1, 2: return (thr == 0) ? 16'h0000 : 16'($urandom_range(0, thr - 1));
      3: return 16'(thr + $urandom_range(0, 2) - 1);
      default: return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
    endcase
  endfunction

  function automatic logic [31:0] sample_word();
    logic [15:0] a, b;
    a = pick_sample();
    b = pick_sample();
    return {a[7:0], a[15:8], b[7:0], b[15:8]};
  endfunction

  // One channel block with random content; now and then noise or a broken frame
  task automatic send_random_block();
    logic [7:0]  ch, bd;
    logic [31:0] w;
    int          n, r;
    if ($urandom_range(0, 9) == 0) send_word($urandom);
    ch = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
    bd = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    send_word({apv_pkg::HEADER_TAG, ch});
    r = $urandom_range(0, 19);
    if (r == 0) begin
      send_word({apv_pkg::HEADER_TAG, 8'($urandom_range(0, 15))});
    end else if (r == 1) begin
      send_word(apv_pkg::TRAILER);
      return;
    end
    w = $urandom;
    w[23:16] = bd;
    send_word(w);
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 8);
    repeat (n) send_word(sample_word());
    // leave some blocks open so the next header closes them
    if ($urandom_range(0, 99) < 80) send_word(apv_pkg::TRAILER);
  endtask

  initial begin
    logic [31:0] directed_words [] = '{
      32'h0000_0000, apv_pkg::TRAILER,
      {apv_pkg::HEADER_TAG, 8'h00}, 32'h0000_0000, 32'hffff_ffff, 32'h0041_4443,
      32'h1234_5678, apv_pkg::TRAILER,
      {apv_pkg::HEADER_TAG, 8'h0f}, 32'h0007_0000, 32'h8000_0001,
      {apv_pkg::HEADER_TAG, 8'h03}, {apv_pkg::HEADER_TAG, 8'h05}, apv_pkg::TRAILER,
      {apv_pkg::HEADER_TAG, 8'hff}, 32'h00ff_0000, 32'h0000_0000, 32'h0000_0000,
      32'h0000_0000, apv_pkg::TRAILER,
      {apv_pkg::HEADER_TAG, 8'h10}, 32'h0003_0000, 32'hfafa_fafb, apv_pkg::TRAILER
    };
    int unsigned phase_end, phase_mid;
    bit          paused;

    raw.valid     <= 1'b0;
    raw.word      <= '0;
    write_enable  <= 1'b0;
    write_index   <= apv_pkg::REG_MAP_LOW;
    write_data    <= '0;
    rst           <= 1'b1;
    gap_pct      = 0;
    stall_pct    = 0;
    holds_asked  = 0;
    settings_used = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle words, active and inactive blocks, early headers and trailers
    write_config(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001,
                 apv_pkg::LOW_THRESHOLD_RESET, apv_pkg::SCAN_LENGTH_RESET);
    foreach (directed_words[i]) send_word(directed_words[i]);
    wait_idle();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: write_config({$urandom, $urandom}, {$urandom, $urandom}, 16'd1500, 10'd100);
        1: write_config('1, '1, 16'hffff, 10'd0);
        2: write_config('0, '0, 16'h0000, 10'd1023);
        3: write_config({$urandom, $urandom}, {$urandom, $urandom}, 16'd3000, 10'd5);
        4: write_config({$urandom, $urandom}, {$urandom, $urandom}, 16'd20000, 10'd1);
        5: write_config('1, '0, 16'($urandom), 10'd2);
        6: write_config({$urandom, $urandom}, {$urandom, $urandom}, 16'd1500,
                        10'($urandom));
        default: write_config({$urandom, $urandom}, {$urandom, $urandom}, 16'd40000,
                              10'd1023);
      endcase
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 45; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 45; end
        default: begin gap_pct = 37; stall_pct = 37; end
      endcase
      if (phase == 0 || phase == 4) holds_asked++;
      paused    = 1'b0;
      phase_end = decode_sb.words_seen + PHASE_WORDS;
      phase_mid = decode_sb.words_seen + PHASE_WORDS / 2;
      while (decode_sb.words_seen < phase_end) begin
        if (phase == 3 && !paused && decode_sb.words_seen >= phase_mid) begin
          wait_idle();
          paused = 1'b1;
        end
        send_random_block();
      end
      wait_idle();
    end

    $display("Checked %0d words: %0d sample items, %0d block ends, %0d low-run warnings.",
             decode_sb.words_seen, decode_sb.samples_checked, decode_sb.ends_checked,
             decode_sb.warnings_checked);
    $display("Ran %0d register settings under sender gaps, receiver stalls and long holds.",
             settings_used);
    if (decode_sb.errors == 0) begin
      $display("apv_frame_stream_decoder regression: pass");
    end else begin
      $display("apv_frame_stream_decoder regression: fail");
    end
    $finish;
  end

endmodule

[apv_frame_stream_decoder.f]
rtl/core/apv_pkg.sv
rtl/core/apv_stream_if.sv
rtl/core/apv_front.sv
rtl/core/apv_queue.sv
rtl/core/apv_back.sv
rtl/core/apv_frame_stream_decoder.sv
rtl/core/apv_checker.sv
verif/apv_frame_stream_decoder_tb.sv
